// ----- src/ogru_pkg.sv -----
// Package for the occupancy grid ray update block: grid sizes, field widths,
// payload structs, register indexes, sequencer states and a small helper.
// Depends on nothing; the top level, ogru_probe and ogru_checker import it.
package ogru_pkg;

   // Grid storage
   localparam int GRID_COLS_MAX = 1024;
   localparam int GRID_ROWS_MAX = 1024;
   localparam int GRID_DEPTH    = GRID_COLS_MAX * GRID_ROWS_MAX;
   localparam int ADDR_W        = $clog2(GRID_DEPTH);
   localparam int COL_W         = $clog2(GRID_COLS_MAX);
   localparam int ROW_W         = $clog2(GRID_ROWS_MAX);

   // Field and datapath widths
   localparam int CELL_W     = 7;
   localparam int DIM_W      = 11;
   localparam int FIELD_W    = 12;
   localparam int COORD_W    = 13;
   localparam int ERR_W      = 14;
   localparam int VALUE_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Constants
   localparam logic [CELL_W-1:0]         CELL_RESET   = 7'd49;
   localparam logic signed [VALUE_W-1:0] CELL_OUTSIDE = -8'sd1;

   // Reset values of the registers
   localparam logic [DIM_W-1:0]  MAP_WIDTH_RESET     = 11'd1024;
   localparam logic [DIM_W-1:0]  MAP_HEIGHT_RESET    = 11'd1024;
   localparam logic [CELL_W-1:0] ADD_AMOUNT_RESET    = 7'd25;
   localparam logic [CELL_W-1:0] REMOVE_AMOUNT_RESET = 7'd10;
   localparam logic [CELL_W-1:0] MAX_VALUE_RESET     = 7'd100;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH     = 3'd0,
      CSR_MAP_HEIGHT    = 3'd1,
      CSR_ADD_AMOUNT    = 3'd2,
      CSR_REMOVE_AMOUNT = 3'd3,
      CSR_MAX_VALUE     = 3'd4
   } csr_index_type;

   // Operation codes
   localparam logic OP_RAY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                      op;
      logic signed [FIELD_W-1:0] robot_x;
      logic signed [FIELD_W-1:0] robot_y;
      logic signed [FIELD_W-1:0] target_x;
      logic signed [FIELD_W-1:0] target_y;
   } req_type;

   typedef struct packed {
      logic                      accepted;
      logic signed [VALUE_W-1:0] cell_value;
   } rsp_type;

   // Outcome of one cell probe: bounds check and linear address
   typedef struct packed {
      logic              in_map;
      logic [ADDR_W-1:0] addr;
   } probe_type;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_PROBE  = 9'b000000100,
      ST_READ   = 9'b000001000,
      ST_MODIFY = 9'b000010000,
      ST_SETUP  = 9'b000100000,
      ST_LOOP   = 9'b001000000,
      ST_STEP   = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   function automatic logic signed [COORD_W-1:0] abs_coord(
      input logic signed [COORD_W-1:0] v
   );
      return v[COORD_W-1] ? -v : v;
   endfunction

endpackage

// ----- src/occupancy_grid_ray_update.sv -----
// Top level of the occupancy grid ray update block: registers, sequencer,
// Bresenham walk and grid store. Depends on ogru_pkg, ogru_probe, ogru_ram.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+----------------------------
//   request | req_valid, req_stall, req_data         | op, robot and target cell
//   result  | rsp_valid, rsp_stall, rsp_data         | accepted, cell_value
//   config  | csr_wr_en, csr_index, csr_wdata        | register write, no read-back
//
// A ray whose target lies outside the map ends without a walk. Each in-map
// cell of a ray costs one read-modify-write on the single grid RAM port
// pair; out-of-map cells are skipped, and a read op only reads its cell.
// After reset a clearing pass writes 49 to all GRID_DEPTH (1048576) cells,
// one per cycle; req_stall stays high meanwhile, register writes still land.
// A finished result waits in the output register; the next request is taken
// while it waits, and the sequencer holds in its last state until it drains.
module occupancy_grid_ray_update
   import ogru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Registers
   logic [DIM_W-1:0]  map_width_ff;
   logic [DIM_W-1:0]  map_height_ff;
   logic [CELL_W-1:0] add_amount_ff;
   logic [CELL_W-1:0] remove_amount_ff;
   logic [CELL_W-1:0] max_value_ff;

   // Sequencer
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              op_ff, op_in;
   logic              walk_ff, walk_in;
   logic              steep_ff, steep_in;
   logic              ys_neg_ff, ys_neg_in;
   logic signed [COORD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_W-1:0] wx_ff, wx_in, wy_ff, wy_in, bx_ff, bx_in;
   logic signed [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Datapath
   logic [DIM_W-1:0]  eff_cols;
   logic [DIM_W-1:0]  eff_rows;
   probe_type         probe;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CELL_W:0]   raise_sum;
   logic [CELL_W-1:0] raised;
   logic [CELL_W-1:0] lowered;
   logic signed [COORD_W-1:0] adx, ady, sax, say, sbx, sby;
   logic signed [COORD_W-1:0] oax, oay, obx, oby, odx;
   logic              setup_steep;
   logic signed [ERR_W-1:0]   err_dec;
   logic              accept;

   // Clamp the dimensions to the grid store
   assign eff_cols = ({2'b00, map_width_ff} > 13'(GRID_COLS_MAX)) ?
                     DIM_W'(GRID_COLS_MAX) : map_width_ff;
   assign eff_rows = ({2'b00, map_height_ff} > 13'(GRID_ROWS_MAX)) ?
                     DIM_W'(GRID_ROWS_MAX) : map_height_ff;

   ogru_probe u_probe (
      .cell_x   (px_ff),
      .cell_y   (py_ff),
      .eff_cols (eff_cols),
      .eff_rows (eff_rows),
      .probe    (probe)
   );

   ogru_ram #(
      .WIDTH (CELL_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // Saturating add for the obstacle, floored subtract for freed cells
   assign raise_sum = {1'b0, ram_rd_data} + {1'b0, add_amount_ff};
   assign raised    = (raise_sum <= {1'b0, max_value_ff}) ? raise_sum[CELL_W-1:0] :
                      max_value_ff;
   assign lowered   = (ram_rd_data > remove_amount_ff) ?
                      (ram_rd_data - remove_amount_ff) : '0;

   // Set up the walk: swap for steep lines, order endpoints by x
   assign adx         = abs_coord(tx_ff - rx_ff);
   assign ady         = abs_coord(ty_ff - ry_ff);
   assign setup_steep = ady > adx;
   assign sax = setup_steep ? ry_ff : rx_ff;
   assign say = setup_steep ? rx_ff : ry_ff;
   assign sbx = setup_steep ? ty_ff : tx_ff;
   assign sby = setup_steep ? tx_ff : ty_ff;
   assign oax = (sax > sbx) ? sbx : sax;
   assign oay = (sax > sbx) ? sby : say;
   assign obx = (sax > sbx) ? sax : sbx;
   assign oby = (sax > sbx) ? say : sby;
   assign odx = obx - oax;

   assign err_dec = err_ff - ERR_W'(dy_ff);
   assign accept  = req_valid && (state_ff == ST_IDLE);

   // Sequencer and walk
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      walk_in      = walk_ff;
      steep_in     = steep_ff;
      ys_neg_in    = ys_neg_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      bx_in        = bx_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = raised;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = CELL_RESET;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(GRID_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_data.op;
               rx_in    = COORD_W'(req_data.robot_x);
               ry_in    = COORD_W'(req_data.robot_y);
               tx_in    = COORD_W'(req_data.target_x);
               ty_in    = COORD_W'(req_data.target_y);
               px_in    = COORD_W'(req_data.target_x);
               py_in    = COORD_W'(req_data.target_y);
               walk_in  = 1'b0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            addr_in = probe.addr;
            if (probe.in_map) begin
               state_in = ST_READ;
            end else if (walk_ff) begin
               state_in = ST_STEP;
            end else begin
               res_in.accepted   = 1'b0;
               res_in.cell_value = (op_ff == OP_READ) ? CELL_OUTSIDE : '0;
               state_in          = ST_DONE;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == OP_READ) begin
               res_in.accepted   = 1'b1;
               res_in.cell_value = {1'b0, ram_rd_data};
               state_in          = ST_DONE;
            end else if (!walk_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = raised;
               state_in    = ST_SETUP;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_data = lowered;
               state_in    = ST_STEP;
            end
         end
         ST_SETUP: begin
            steep_in  = setup_steep;
            wx_in     = oax;
            wy_in     = oay;
            bx_in     = obx;
            dx_in     = odx;
            dy_in     = abs_coord(oby - oay);
            err_in    = ERR_W'(odx >>> 1);
            ys_neg_in = !(oay < oby);
            walk_in   = 1'b1;
            state_in  = ST_LOOP;
         end
         ST_LOOP: begin
            if (wx_ff < bx_ff) begin
               px_in    = steep_ff ? wy_ff : wx_ff;
               py_in    = steep_ff ? wx_ff : wy_ff;
               state_in = ST_PROBE;
            end else begin
               res_in.accepted   = 1'b1;
               res_in.cell_value = '0;
               state_in          = ST_DONE;
            end
         end
         ST_STEP: begin
            // Advance x, step y when the error goes negative
            wx_in = wx_ff + COORD_W'(1);
            if (err_dec < 0) begin
               err_in = err_dec + ERR_W'(dx_ff);
               wy_in  = ys_neg_ff ? (wy_ff - COORD_W'(1)) : (wy_ff + COORD_W'(1));
            end else begin
               err_in = err_dec;
            end
            state_in = ST_LOOP;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      walk_ff     <= walk_in;
      steep_ff    <= steep_in;
      ys_neg_ff   <= ys_neg_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      wx_ff       <= wx_in;
      wy_ff       <= wy_in;
      bx_ff       <= bx_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      addr_ff     <= addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= MAP_WIDTH_RESET;
         map_height_ff    <= MAP_HEIGHT_RESET;
         add_amount_ff    <= ADD_AMOUNT_RESET;
         remove_amount_ff <= REMOVE_AMOUNT_RESET;
         max_value_ff     <= MAX_VALUE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:     map_width_ff     <= csr_wdata;
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_wdata;
            CSR_ADD_AMOUNT:    add_amount_ff    <= csr_wdata[CELL_W-1:0];
            CSR_REMOVE_AMOUNT: remove_amount_ff <= csr_wdata[CELL_W-1:0];
            CSR_MAX_VALUE:     max_value_ff     <= csr_wdata[CELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/ogru_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ogru_probe.sv -----
// Cell probe: bounds check of one cell against the map in use and its
// linear address x + y * width. Depends on ogru_pkg.
module ogru_probe
   import ogru_pkg::*;
(
   input  logic signed [COORD_W-1:0] cell_x,
   input  logic signed [COORD_W-1:0] cell_y,
   input  logic [DIM_W-1:0]          eff_cols,
   input  logic [DIM_W-1:0]          eff_rows,
   output probe_type                 probe
);

   logic                    x_ok;
   logic                    y_ok;
   logic [ROW_W+DIM_W-1:0]  row_base;

   // Check both coordinates against zero and the dimension in use
   assign x_ok = !cell_x[COORD_W-1] &&
                 ({1'b0, cell_x[COORD_W-2:0]} < {{(COORD_W-DIM_W){1'b0}}, eff_cols});
   assign y_ok = !cell_y[COORD_W-1] &&
                 ({1'b0, cell_y[COORD_W-2:0]} < {{(COORD_W-DIM_W){1'b0}}, eff_rows});

   // Form the row base with the one multiplier, then add the column
   assign row_base     = cell_y[ROW_W-1:0] * eff_cols;
   assign probe.in_map = x_ok && y_ok;
   assign probe.addr   = ADDR_W'(row_base) + ADDR_W'(cell_x[COL_W-1:0]);

endmodule

// ----- src/ogru_checker.sv -----
// Port-level checker for the occupancy grid ray update block, bound to the
// top level. Depends on ogru_pkg and occupancy_grid_ray_update.
module ogru_checker
   import ogru_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_type               rsp_data,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Clearing pass blocks requests straight after reset
   assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("request side open during clearing pass");

   // One item at a time: a request transfer closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   // A presented result carries known bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result presented with unknown bits");

   // Rejected items carry zero or the outside marker; accepted ones are beliefs
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.accepted && !rsp_data.cell_value[VALUE_W-1]) ||
                    (!rsp_data.accepted && (rsp_data.cell_value == CELL_OUTSIDE ||
                                            rsp_data.cell_value == '0)))
      else $error("result value does not fit its accepted flag");

endmodule

bind occupancy_grid_ray_update ogru_checker u_ogru_checker (.*);
